### src/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants for the segment collision test pipeline.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int RADIUS_WIDTH    = 15;
    localparam int OP_WIDTH        = 2;
    localparam int CFG_IDX_WIDTH   = 3;
    localparam int PIPE_DEPTH      = 6;

    localparam logic [OP_WIDTH-1:0] OP_POINT   = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_CIRCLE  = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_SEGMENT = 2'd2;
    localparam logic [OP_WIDTH-1:0] OP_NONE    = 2'd3;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_START_X  = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_START_Y  = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_END_X    = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_END_Y    = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_OFFSET_X = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_OFFSET_Y = 3'd5;

    typedef struct packed {
        logic                valid;
        logic [OP_WIDTH-1:0] op;
    } t_ctl;

    typedef struct packed {
        logic point_hit;
        logic seg_hit;
        logic len_zero;
        logic near_start;
        logic span_ok;
    } t_flags;

endpackage

### src/segment_collision_test.sv
// ----------------------------------------------------------------------------
// segment_collision_test
// Exact integer point, circle and segment hit tests against one configured
// 2D segment, in a six-stage pipeline.
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   --------------------------------------
//  command   i_start / o_busy          i_operation, i_query_*, i_radius,
//                                      i_other_start_*, i_other_end_*
//  result    o_done strobe             o_hit
//  config    i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//
// A command word is taken in every cycle; o_busy stays low.
// Each result appears on o_hit with o_done once its command has passed the
// diff, multiplier, wide and decide stages in turn.
// Reset clears the pipeline valid bits and all segment registers to zero.
// The receiver cannot stall, so no stage ever holds.
// ----------------------------------------------------------------------------
module segment_collision_test
    import sct_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic        [OP_WIDTH-1:0]     i_operation,
    input  logic signed [COORD_WIDTH-1:0]  i_query_x,
    input  logic signed [COORD_WIDTH-1:0]  i_query_y,
    input  logic        [RADIUS_WIDTH-1:0] i_radius,
    input  logic signed [COORD_WIDTH-1:0]  i_other_start_x,
    input  logic signed [COORD_WIDTH-1:0]  i_other_start_y,
    input  logic signed [COORD_WIDTH-1:0]  i_other_end_x,
    input  logic signed [COORD_WIDTH-1:0]  i_other_end_y,
    output logic                           o_done,
    output logic                           o_hit,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic        [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic        [COORD_WIDTH-1:0]  i_cfg_data
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int AW = COORD_WIDTH + 2;
    localparam int SW = 2 * COORD_WIDTH + 5;
    localparam int RW = 2 * RADIUS_WIDTH;

    logic signed [COORD_WIDTH-1:0] r_seg_start_x, r_seg_start_y;
    logic signed [COORD_WIDTH-1:0] r_seg_end_x, r_seg_end_y;
    logic signed [COORD_WIDTH-1:0] r_seg_offset_x, r_seg_offset_y;

    t_ctl                    in_ctl, d_ctl, m_ctl, w_ctl;
    t_flags                  w_flags;
    logic signed [DW-1:0]    d_lx, d_ly, d_vbx, d_vby;
    logic signed [AW-1:0]    d_ax, d_ay, d_bx, d_by, d_cx, d_cy;
    logic [RADIUS_WIDTH-1:0] d_radius;
    logic signed [SW-1:0]    m_cr, m_dl, m_ll, m_aa, m_bb, m_d, m_na, m_nb;
    logic [RW-1:0]           m_rr;
    logic signed [2*COORD_WIDTH+7:0]              w_p_hh;
    logic signed [2*COORD_WIDTH+5:0]              w_p_hl;
    logic        [2*COORD_WIDTH+1:0]              w_p_ll;
    logic        [2*RADIUS_WIDTH+COORD_WIDTH+3:0] w_q_h;
    logic        [2*RADIUS_WIDTH+COORD_WIDTH:0]   w_q_l;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_start_x  <= '0;
            r_seg_start_y  <= '0;
            r_seg_end_x    <= '0;
            r_seg_end_y    <= '0;
            r_seg_offset_x <= '0;
            r_seg_offset_y <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_START_X:  r_seg_start_x  <= i_cfg_data;
                REG_START_Y:  r_seg_start_y  <= i_cfg_data;
                REG_END_X:    r_seg_end_x    <= i_cfg_data;
                REG_END_Y:    r_seg_end_y    <= i_cfg_data;
                REG_OFFSET_X: r_seg_offset_x <= i_cfg_data;
                REG_OFFSET_Y: r_seg_offset_y <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign in_ctl.valid = i_start && !o_busy;
    assign in_ctl.op    = i_operation;

    sct_diff #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (in_ctl),
        .i_query_x       (i_query_x),
        .i_query_y       (i_query_y),
        .i_radius        (i_radius),
        .i_other_start_x (i_other_start_x),
        .i_other_start_y (i_other_start_y),
        .i_other_end_x   (i_other_end_x),
        .i_other_end_y   (i_other_end_y),
        .i_seg_start_x   (r_seg_start_x),
        .i_seg_start_y   (r_seg_start_y),
        .i_seg_end_x     (r_seg_end_x),
        .i_seg_end_y     (r_seg_end_y),
        .i_seg_offset_x  (r_seg_offset_x),
        .i_seg_offset_y  (r_seg_offset_y),
        .o_ctl           (d_ctl),
        .o_lx            (d_lx),
        .o_ly            (d_ly),
        .o_vbx           (d_vbx),
        .o_vby           (d_vby),
        .o_ax            (d_ax),
        .o_ay            (d_ay),
        .o_bx            (d_bx),
        .o_by            (d_by),
        .o_cx            (d_cx),
        .o_cy            (d_cy),
        .o_radius        (d_radius)
    );

    sct_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (d_ctl),
        .i_lx     (d_lx),
        .i_ly     (d_ly),
        .i_vbx    (d_vbx),
        .i_vby    (d_vby),
        .i_ax     (d_ax),
        .i_ay     (d_ay),
        .i_bx     (d_bx),
        .i_by     (d_by),
        .i_cx     (d_cx),
        .i_cy     (d_cy),
        .i_radius (d_radius),
        .o_ctl    (m_ctl),
        .o_cr     (m_cr),
        .o_dl     (m_dl),
        .o_ll     (m_ll),
        .o_aa     (m_aa),
        .o_bb     (m_bb),
        .o_d      (m_d),
        .o_na     (m_na),
        .o_nb     (m_nb),
        .o_rr     (m_rr)
    );

    sct_wide #(.COORD_WIDTH(COORD_WIDTH)) u_wide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (m_ctl),
        .i_cr    (m_cr),
        .i_dl    (m_dl),
        .i_ll    (m_ll),
        .i_aa    (m_aa),
        .i_bb    (m_bb),
        .i_d     (m_d),
        .i_na    (m_na),
        .i_nb    (m_nb),
        .i_rr    (m_rr),
        .o_ctl   (w_ctl),
        .o_flags (w_flags),
        .o_p_hh  (w_p_hh),
        .o_p_hl  (w_p_hl),
        .o_p_ll  (w_p_ll),
        .o_q_h   (w_q_h),
        .o_q_l   (w_q_l)
    );

    sct_decide #(.COORD_WIDTH(COORD_WIDTH)) u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_flags (w_flags),
        .i_p_hh  (w_p_hh),
        .i_p_hl  (w_p_hl),
        .i_p_ll  (w_p_ll),
        .i_q_h   (w_q_h),
        .i_q_l   (w_q_l),
        .o_done  (o_done),
        .o_hit   (o_hit)
    );

    // Every accepted command word yields exactly one result after the pipeline depth.
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##PIPE_DEPTH o_done)
        else $error("accepted command produced no result");

    a_start_precedes_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, PIPE_DEPTH))
        else $error("result without a matching command");

    a_unused_op_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit) |-> ($past(i_operation, PIPE_DEPTH) != OP_NONE))
        else $error("hit reported for the unused operation code");

    a_hit_only_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> o_done)
        else $error("hit raised outside a result cycle");

endmodule

### src/sct_diff.sv
// ----------------------------------------------------------------------------
// sct_diff
// First stage: forms the segment and other-segment vectors and the difference
// vectors between the query and the configured segment in world coordinates.
// ----------------------------------------------------------------------------
module sct_diff
    import sct_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_ctl                           i_ctl,
    input  logic signed [COORD_WIDTH-1:0]  i_query_x,
    input  logic signed [COORD_WIDTH-1:0]  i_query_y,
    input  logic        [RADIUS_WIDTH-1:0] i_radius,
    input  logic signed [COORD_WIDTH-1:0]  i_other_start_x,
    input  logic signed [COORD_WIDTH-1:0]  i_other_start_y,
    input  logic signed [COORD_WIDTH-1:0]  i_other_end_x,
    input  logic signed [COORD_WIDTH-1:0]  i_other_end_y,
    input  logic signed [COORD_WIDTH-1:0]  i_seg_start_x,
    input  logic signed [COORD_WIDTH-1:0]  i_seg_start_y,
    input  logic signed [COORD_WIDTH-1:0]  i_seg_end_x,
    input  logic signed [COORD_WIDTH-1:0]  i_seg_end_y,
    input  logic signed [COORD_WIDTH-1:0]  i_seg_offset_x,
    input  logic signed [COORD_WIDTH-1:0]  i_seg_offset_y,
    output t_ctl                           o_ctl,
    output logic signed [COORD_WIDTH:0]    o_lx,
    output logic signed [COORD_WIDTH:0]    o_ly,
    output logic signed [COORD_WIDTH:0]    o_vbx,
    output logic signed [COORD_WIDTH:0]    o_vby,
    output logic signed [COORD_WIDTH+1:0]  o_ax,
    output logic signed [COORD_WIDTH+1:0]  o_ay,
    output logic signed [COORD_WIDTH+1:0]  o_bx,
    output logic signed [COORD_WIDTH+1:0]  o_by,
    output logic signed [COORD_WIDTH+1:0]  o_cx,
    output logic signed [COORD_WIDTH+1:0]  o_cy,
    output logic        [RADIUS_WIDTH-1:0] o_radius
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int AW = COORD_WIDTH + 2;

    logic signed [DW-1:0] n_wsx, n_wsy, n_wex, n_wey, n_osqx, n_osqy;
    logic signed [DW-1:0] n_lx, n_ly, n_vbx, n_vby;
    logic signed [AW-1:0] n_ax, n_ay, n_bx, n_by, n_cx, n_cy;

    t_ctl                  r_ctl;
    logic signed [DW-1:0]  r_lx, r_ly, r_vbx, r_vby;
    logic signed [AW-1:0]  r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [RADIUS_WIDTH-1:0] r_radius;

    assign n_wsx  = i_seg_start_x + i_seg_offset_x;
    assign n_wsy  = i_seg_start_y + i_seg_offset_y;
    assign n_wex  = i_seg_end_x + i_seg_offset_x;
    assign n_wey  = i_seg_end_y + i_seg_offset_y;
    assign n_osqx = i_other_start_x + i_query_x;
    assign n_osqy = i_other_start_y + i_query_y;

    assign n_lx  = i_seg_end_x - i_seg_start_x;
    assign n_ly  = i_seg_end_y - i_seg_start_y;
    assign n_vbx = i_other_end_x - i_other_start_x;
    assign n_vby = i_other_end_y - i_other_start_y;
    assign n_ax  = i_query_x - n_wsx;
    assign n_ay  = i_query_y - n_wsy;
    assign n_bx  = i_query_x - n_wex;
    assign n_by  = i_query_y - n_wey;
    assign n_cx  = n_osqx - n_wsx;
    assign n_cy  = n_osqy - n_wsy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lx     <= n_lx;
        r_ly     <= n_ly;
        r_vbx    <= n_vbx;
        r_vby    <= n_vby;
        r_ax     <= n_ax;
        r_ay     <= n_ay;
        r_bx     <= n_bx;
        r_by     <= n_by;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_radius <= i_radius;
    end

    assign o_ctl    = r_ctl;
    assign o_lx     = r_lx;
    assign o_ly     = r_ly;
    assign o_vbx    = r_vbx;
    assign o_vby    = r_vby;
    assign o_ax     = r_ax;
    assign o_ay     = r_ay;
    assign o_bx     = r_bx;
    assign o_by     = r_by;
    assign o_cx     = r_cx;
    assign o_cy     = r_cy;
    assign o_radius = r_radius;

endmodule

### src/sct_mul.sv
// ----------------------------------------------------------------------------
// sct_mul
// Second and third stages: all coordinate products, then the cross
// products, dot products and squared lengths built from them.
// ----------------------------------------------------------------------------
module sct_mul
    import sct_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_ctl                             i_ctl,
    input  logic signed [COORD_WIDTH:0]      i_lx,
    input  logic signed [COORD_WIDTH:0]      i_ly,
    input  logic signed [COORD_WIDTH:0]      i_vbx,
    input  logic signed [COORD_WIDTH:0]      i_vby,
    input  logic signed [COORD_WIDTH+1:0]    i_ax,
    input  logic signed [COORD_WIDTH+1:0]    i_ay,
    input  logic signed [COORD_WIDTH+1:0]    i_bx,
    input  logic signed [COORD_WIDTH+1:0]    i_by,
    input  logic signed [COORD_WIDTH+1:0]    i_cx,
    input  logic signed [COORD_WIDTH+1:0]    i_cy,
    input  logic        [RADIUS_WIDTH-1:0]   i_radius,
    output t_ctl                             o_ctl,
    output logic signed [2*COORD_WIDTH+4:0]  o_cr,
    output logic signed [2*COORD_WIDTH+4:0]  o_dl,
    output logic signed [2*COORD_WIDTH+4:0]  o_ll,
    output logic signed [2*COORD_WIDTH+4:0]  o_aa,
    output logic signed [2*COORD_WIDTH+4:0]  o_bb,
    output logic signed [2*COORD_WIDTH+4:0]  o_d,
    output logic signed [2*COORD_WIDTH+4:0]  o_na,
    output logic signed [2*COORD_WIDTH+4:0]  o_nb,
    output logic        [2*RADIUS_WIDTH-1:0] o_rr
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int AW = COORD_WIDTH + 2;
    localparam int SW = 2 * COORD_WIDTH + 5;
    localparam int RW = 2 * RADIUS_WIDTH;

    t_ctl                    r_ctl2, r_ctl3;
    logic signed [DW+AW-1:0] r_lxay, r_lyax, r_axlx, r_ayly;
    logic signed [DW+AW-1:0] r_cxvb, r_cyvb, r_cxly, r_cylx;
    logic signed [2*DW-1:0]  r_lxlx, r_lyly, r_lxvb, r_lyvb;
    logic signed [2*AW-1:0]  r_axax, r_ayay, r_bxbx, r_byby;
    logic        [RW-1:0]    r_rr2, r_rr3;
    logic signed [SW-1:0]    r_cr, r_dl, r_ll, r_aa, r_bb, r_d, r_na, r_nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else begin
            r_ctl2 <= i_ctl;
            r_ctl3 <= r_ctl2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lxay <= i_lx * i_ay;
        r_lyax <= i_ly * i_ax;
        r_axlx <= i_ax * i_lx;
        r_ayly <= i_ay * i_ly;
        r_lxlx <= i_lx * i_lx;
        r_lyly <= i_ly * i_ly;
        r_axax <= i_ax * i_ax;
        r_ayay <= i_ay * i_ay;
        r_bxbx <= i_bx * i_bx;
        r_byby <= i_by * i_by;
        r_lxvb <= i_lx * i_vby;
        r_lyvb <= i_ly * i_vbx;
        r_cxvb <= i_cx * i_vby;
        r_cyvb <= i_cy * i_vbx;
        r_cxly <= i_cx * i_ly;
        r_cylx <= i_cy * i_lx;
        r_rr2  <= i_radius * i_radius;
    end

    always_ff @(posedge i_clk) begin
        r_cr  <= SW'(r_lxay) - SW'(r_lyax);
        r_dl  <= SW'(r_axlx) + SW'(r_ayly);
        r_ll  <= SW'(r_lxlx) + SW'(r_lyly);
        r_aa  <= SW'(r_axax) + SW'(r_ayay);
        r_bb  <= SW'(r_bxbx) + SW'(r_byby);
        r_d   <= SW'(r_lxvb) - SW'(r_lyvb);
        r_na  <= SW'(r_cxvb) - SW'(r_cyvb);
        r_nb  <= SW'(r_cxly) - SW'(r_cylx);
        r_rr3 <= r_rr2;
    end

    assign o_ctl = r_ctl3;
    assign o_cr  = r_cr;
    assign o_dl  = r_dl;
    assign o_ll  = r_ll;
    assign o_aa  = r_aa;
    assign o_bb  = r_bb;
    assign o_d   = r_d;
    assign o_na  = r_na;
    assign o_nb  = r_nb;
    assign o_rr  = r_rr3;

endmodule

### src/sct_wide.sv
// ----------------------------------------------------------------------------
// sct_wide
// Fourth stage: partial products of the squared cross product and of
// r^2 * |l|^2, and all the narrow compares of the three tests.
// ----------------------------------------------------------------------------
module sct_wide
    import sct_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  t_ctl                                          i_ctl,
    input  logic signed [2*COORD_WIDTH+4:0]               i_cr,
    input  logic signed [2*COORD_WIDTH+4:0]               i_dl,
    input  logic signed [2*COORD_WIDTH+4:0]               i_ll,
    input  logic signed [2*COORD_WIDTH+4:0]               i_aa,
    input  logic signed [2*COORD_WIDTH+4:0]               i_bb,
    input  logic signed [2*COORD_WIDTH+4:0]               i_d,
    input  logic signed [2*COORD_WIDTH+4:0]               i_na,
    input  logic signed [2*COORD_WIDTH+4:0]               i_nb,
    input  logic        [2*RADIUS_WIDTH-1:0]              i_rr,
    output t_ctl                                          o_ctl,
    output t_flags                                        o_flags,
    output logic signed [2*COORD_WIDTH+7:0]               o_p_hh,
    output logic signed [2*COORD_WIDTH+5:0]               o_p_hl,
    output logic        [2*COORD_WIDTH+1:0]               o_p_ll,
    output logic        [2*RADIUS_WIDTH+COORD_WIDTH+3:0]  o_q_h,
    output logic        [2*RADIUS_WIDTH+COORD_WIDTH:0]    o_q_l
);

    localparam int SW = 2 * COORD_WIDTH + 5;
    localparam int RW = 2 * RADIUS_WIDTH;
    localparam int H  = COORD_WIDTH + 1;
    localparam int HW = SW - H;
    localparam int KW = (SW > RW + 1) ? SW : RW + 1;

    logic signed [HW-1:0] n_ch;
    logic signed [H:0]    n_cl;
    logic signed [KW-1:0] n_aa_k, n_bb_k, n_rr_k;
    t_flags               n_flags;

    t_ctl                  r_ctl;
    t_flags                r_flags;
    logic signed [2*HW-1:0] r_p_hh;
    logic signed [HW+H:0]  r_p_hl;
    logic [2*H-1:0]        r_p_ll;
    logic [RW+HW-1:0]      r_q_h;
    logic [RW+H-1:0]       r_q_l;

    assign n_ch   = i_cr[SW-1:H];
    assign n_cl   = {1'b0, i_cr[H-1:0]};
    assign n_aa_k = KW'(i_aa);
    assign n_bb_k = KW'(i_bb);
    assign n_rr_k = KW'(i_rr);

    always_comb begin
        n_flags.point_hit  = (i_cr == '0) && (i_dl >= 0) && (i_aa <= i_ll);
        n_flags.len_zero   = (i_ll == '0);
        n_flags.near_start = (n_aa_k <= n_rr_k);
        n_flags.span_ok    = ((i_dl >= 0) && (i_dl <= i_ll)) || (n_aa_k <= n_rr_k)
                             || (n_bb_k <= n_rr_k);
        if (i_d > 0) begin
            n_flags.seg_hit = (i_na >= 0) && (i_na <= i_d) && (i_nb >= 0) && (i_nb <= i_d);
        end else if (i_d < 0) begin
            n_flags.seg_hit = (i_na <= 0) && (i_na >= i_d) && (i_nb <= 0) && (i_nb >= i_d);
        end else begin
            n_flags.seg_hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags <= n_flags;
        r_p_hh  <= n_ch * n_ch;
        r_p_hl  <= n_ch * n_cl;
        r_p_ll  <= i_cr[H-1:0] * i_cr[H-1:0];
        r_q_h   <= i_rr * i_ll[SW-1:H];
        r_q_l   <= i_rr * i_ll[H-1:0];
    end

    assign o_ctl   = r_ctl;
    assign o_flags = r_flags;
    assign o_p_hh  = r_p_hh;
    assign o_p_hl  = r_p_hl;
    assign o_p_ll  = r_p_ll;
    assign o_q_h   = r_q_h;
    assign o_q_l   = r_q_l;

endmodule

### src/sct_decide.sv
// ----------------------------------------------------------------------------
// sct_decide
// Fifth and sixth stages: sums the partial products into the two wide
// circle terms, compares them and selects the answer of the operation.
// ----------------------------------------------------------------------------
module sct_decide
    import sct_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  t_ctl                                          i_ctl,
    input  t_flags                                        i_flags,
    input  logic signed [2*COORD_WIDTH+7:0]               i_p_hh,
    input  logic signed [2*COORD_WIDTH+5:0]               i_p_hl,
    input  logic        [2*COORD_WIDTH+1:0]               i_p_ll,
    input  logic        [2*RADIUS_WIDTH+COORD_WIDTH+3:0]  i_q_h,
    input  logic        [2*RADIUS_WIDTH+COORD_WIDTH:0]    i_q_l,
    output logic                                          o_done,
    output logic                                          o_hit
);

    localparam int RW = 2 * RADIUS_WIDTH;
    localparam int H  = COORD_WIDTH + 1;
    localparam int CA = 4 * COORD_WIDTH + 5;
    localparam int CB = 2 * COORD_WIDTH + RW + 2;
    localparam int CW = ((CA > CB) ? CA : CB) + 1;

    t_ctl                 r_ctl5, r_ctl6;
    t_flags               r_flags5;
    logic signed [CW-1:0] r_cr2;
    logic        [CW-1:0] r_rl;
    logic                 n_hit;
    logic                 r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl5 <= '0;
            r_ctl6 <= '0;
        end else begin
            r_ctl5 <= i_ctl;
            r_ctl6 <= r_ctl5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags5 <= i_flags;
        r_cr2    <= (CW'(i_p_hh) <<< (2 * H)) + (CW'(i_p_hl) <<< (H + 1)) + CW'(i_p_ll);
        r_rl     <= (CW'(i_q_h) << H) + CW'(i_q_l);
    end

    always_comb begin
        case (r_ctl5.op)
            OP_POINT:   n_hit = r_flags5.point_hit;
            OP_CIRCLE:  n_hit = r_flags5.len_zero ? r_flags5.near_start
                                : ((r_cr2 <= $signed(r_rl)) && r_flags5.span_ok);
            OP_SEGMENT: n_hit = r_flags5.seg_hit;
            default:    n_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= r_ctl5.valid && n_hit;
        end
    end

    assign o_done = r_ctl6.valid;
    assign o_hit  = r_hit;

endmodule
